// ===== hdl/gdad_pkg.sv =====
// Package for the Gregorian date adder: field widths, calendar constants
// and the small calendar functions used by the core.
// No dependencies.
package gdad_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int CNT_W  = 15;
  // Working width: year count, day count and the mod-400 reduction share it
  localparam int OP_W   = 15;
  localparam int DOY_W  = 9;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam logic [OP_W-1:0]  MOD_BASE  = 15'd400;
  localparam logic [OP_W-1:0]  MOD_LAST  = 15'd399;
  localparam logic [2:0]       MOD_STEPS = 3'd5;

  localparam logic [DOY_W-1:0] DAYS_LEAP = 9'd366;
  localparam logic [DOY_W-1:0] DAYS_NORM = 9'd365;

  typedef struct packed {
    logic start;     // input word offered and core is idle
    logic out_free;  // result register can take a word this cycle
  } gdad_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } gdad_stat_t;

  // Leap test on the year reduced modulo 400
  function automatic logic is_leap(input logic [DOY_W-1:0] r);
    logic cent;
    cent = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r == '0) || ((r[1:0] == 2'b00) && !cent);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_FEB:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before month m (non-leap year)
  function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/gregorian_date_add_days.sv =====
// Gregorian date adder: start date plus a day count gives the later date.
// Input channel: in_valid/in_stall with in_start_year, in_start_month,
// in_start_day, in_days_to_add. Result channel: out_valid/out_stall with
// out_result_year, out_result_month, out_result_day. A word moves on a
// rising edge where valid is high and stall is low.
// The core jumps Y whole years (at most about 90) and then M whole months
// (at most 11). The year reduction and the year and month jumps run through
// a single 15-bit compare-and-subtract unit, one step per cycle: six for the
// year modulo 400, one per year or month jump, one to close each stepping
// phase. A new word is taken only when the core is idle, so one word is in
// work at a time.
// The result sits in an output register; the core finishes its next word
// up to the result step and holds there while the receiver stalls.
// Reset (rst_n low, synchronous) drops any word in work and clears out_valid.
// Depends on gdad_pkg, gdad_core and gdad_sub.
module gregorian_date_add_days (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gdad_pkg::YEAR_W-1:0]  in_start_year,
  input  logic [gdad_pkg::MON_W-1:0]   in_start_month,
  input  logic [gdad_pkg::DAY_W-1:0]   in_start_day,
  input  logic [gdad_pkg::CNT_W-1:0]   in_days_to_add,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gdad_pkg::YEAR_W-1:0]  out_result_year,
  output logic [gdad_pkg::MON_W-1:0]   out_result_month,
  output logic [gdad_pkg::DAY_W-1:0]   out_result_day
);
  import gdad_pkg::*;

  gdad_req_t        req;
  gdad_stat_t       stat;
  logic             out_valid_r;
  logic [YEAR_W-1:0] year_r;
  logic [MON_W-1:0] month_r;
  logic [DAY_W-1:0] day_r;
  logic [YEAR_W-1:0] res_year;
  logic [MON_W-1:0] res_month;
  logic [DAY_W-1:0] res_day;

  assign req.start    = in_valid && stat.idle;
  assign req.out_free = !out_valid_r || !out_stall;
  assign in_stall     = !stat.idle;

  gdad_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .start_year  (in_start_year),
    .start_month (in_start_month),
    .start_day   (in_start_day),
    .days_to_add (in_days_to_add),
    .stat        (stat),
    .res_year    (res_year),
    .res_month   (res_month),
    .res_day     (res_day)
  );

  // Load a finished word, hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (stat.done) begin
      year_r  <= res_year;
      month_r <= res_month;
      day_r   <= res_day;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = year_r;
  assign out_result_month = month_r;
  assign out_result_day   = day_r;

endmodule

// ===== hdl/gdad_sub.sv =====
// Shared compare-and-subtract unit of the date adder.
// Depends on gdad_pkg for the operand width.
module gdad_sub (
  input  logic [gdad_pkg::OP_W-1:0] op_a,
  input  logic [gdad_pkg::OP_W-1:0] op_b,
  output logic [gdad_pkg::OP_W-1:0] diff,
  output logic                      ge
);
  import gdad_pkg::*;

  logic borrow;

  assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
  assign ge = !borrow;

endmodule

// ===== hdl/gdad_core.sv =====
// Sequencer and working registers of the date adder: reduce the year mod 400,
// then step whole years, whole months, and finish with the day add.
// Depends on gdad_pkg and gdad_sub.
module gdad_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gdad_pkg::gdad_req_t          req,
  input  logic [gdad_pkg::YEAR_W-1:0]  start_year,
  input  logic [gdad_pkg::MON_W-1:0]   start_month,
  input  logic [gdad_pkg::DAY_W-1:0]   start_day,
  input  logic [gdad_pkg::CNT_W-1:0]   days_to_add,
  output gdad_pkg::gdad_stat_t         stat,
  output logic [gdad_pkg::YEAR_W-1:0]  res_year,
  output logic [gdad_pkg::MON_W-1:0]   res_month,
  output logic [gdad_pkg::DAY_W-1:0]   res_day
);
  import gdad_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_FIX   = 3'd2;
  localparam logic [2:0] ST_YEAR  = 3'd3;
  localparam logic [2:0] ST_MONTH = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [OP_W-1:0]  y_r, y_nxt;
  logic [OP_W-1:0]  r_r, r_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [MON_W-1:0] m_r, m_nxt;
  logic [DAY_W-1:0] d_r, d_nxt;
  logic [DOY_W-1:0] passed_r, passed_nxt;

  logic [OP_W-1:0]  op_a, op_b, diff;
  logic             ge;
  logic             leap;
  logic [DAY_W-1:0] mlen;
  logic [DOY_W-1:0] ylen, ygap;
  logic [DAY_W:0]   mgap;
  logic [DAY_W-1:0] d_fix;
  logic [MON_W-1:0] m_in;

  gdad_sub u_sub (
    .op_a (op_a),
    .op_b (op_b),
    .diff (diff),
    .ge   (ge)
  );

  assign leap = is_leap(r_r[DOY_W-1:0]);
  assign mlen = month_len(m_r, leap);
  assign ylen = leap ? DAYS_LEAP : DAYS_NORM;
  assign ygap = ylen - passed_r + 9'd1;
  assign mgap = {1'b0, mlen} - {1'b0, d_r} + 6'd1;

  always_comb begin
    if (start_month < MON_JAN) begin
      m_in = MON_JAN;
    end else if (start_month > MON_DEC) begin
      m_in = MON_DEC;
    end else begin
      m_in = start_month;
    end
    if (d_r == '0) begin
      d_fix = 5'd1;
    end else if (d_r > mlen) begin
      d_fix = mlen;
    end else begin
      d_fix = d_r;
    end
  end

  // Operand select for the shared subtractor
  always_comb begin
    op_a = rem_r;
    op_b = OP_W'(ygap);
    case (state_r)
      ST_MOD: begin
        op_a = r_r;
        op_b = MOD_BASE << k_r;
      end
      ST_MONTH: op_b = OP_W'(mgap);
      default:  op_b = OP_W'(ygap);
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    y_nxt      = y_r;
    r_nxt      = r_r;
    rem_nxt    = rem_r;
    m_nxt      = m_r;
    d_nxt      = d_r;
    passed_nxt = passed_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          y_nxt     = OP_W'(start_year);
          r_nxt     = OP_W'(start_year);
          m_nxt     = m_in;
          d_nxt     = start_day;
          rem_nxt   = days_to_add;
          k_nxt     = MOD_STEPS;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (ge) begin
          r_nxt = diff;
        end
        k_nxt = k_r - 3'd1;
        if (k_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        d_nxt      = d_fix;
        passed_nxt = days_before(m_r) + DOY_W'(d_fix)
                   + ((leap && (m_r > MON_FEB)) ? 9'd1 : 9'd0);
        state_nxt  = ST_YEAR;
      end
      ST_YEAR: begin
        // jump to January 1 of next year while the count reaches past year end
        if (ge) begin
          rem_nxt    = diff;
          y_nxt      = y_r + 15'd1;
          r_nxt      = (r_r == MOD_LAST) ? '0 : r_r + 15'd1;
          m_nxt      = MON_JAN;
          d_nxt      = 5'd1;
          passed_nxt = 9'd1;
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (ge) begin
          rem_nxt = diff;
          m_nxt   = m_r + 4'd1;
          d_nxt   = 5'd1;
        end else begin
          d_nxt     = d_r + rem_r[DAY_W-1:0];
          rem_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (req.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r      <= k_nxt;
    y_r      <= y_nxt;
    r_r      <= r_nxt;
    rem_r    <= rem_nxt;
    m_r      <= m_nxt;
    d_r      <= d_nxt;
    passed_r <= passed_nxt;
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_DONE) && req.out_free;
  assign res_year  = y_r[YEAR_W-1:0];
  assign res_month = m_r;
  assign res_day   = d_r;

  a_mod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIX |-> r_r < MOD_BASE)
    else $error("year residue not reduced below 400");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR || state_r == ST_MONTH) |-> (m_r >= MON_JAN && m_r <= MON_DEC))
    else $error("month left 1..12 while stepping");

  a_rem_falls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR || state_r == ST_MONTH) |=> rem_r <= $past(rem_r))
    else $error("day count grew while stepping");

  a_day_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> (d_r != '0 && d_r <= mlen))
    else $error("result day outside its month");

endmodule
